### rtl/spcrc_pkg.sv
`default_nettype none
package spcrc_pkg;

    localparam int HEADER_BYTES_DEF = 128;
    localparam int FIELD_BITS_DEF   = 32;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8005;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_PATCH = 1'b1;

    localparam int PROTECT_POS   = 1;
    localparam int CRC_START_POS = 2;
    localparam int CRC_SKIP_HI   = 4;
    localparam int CRC_SKIP_LO   = 5;

    localparam logic [6:0] PATCH_INDEX = 7'd4;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  length;
        logic        last;
    } t_item;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            if (c[15] ^ b[k]) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/side_info_packer_crc16.sv
`default_nettype none
// Bit-field header packer with CRC-16. Fields enter through a two-entry queue; a byte
// sequencer behind it appends the bits MSB first and hands out one completed byte per
// cycle unless the output stall holds it, folding each protected byte into the CRC-16
// (0x8005, start 0xFFFF) in that same cycle. An item is loaded from the queue, then the
// sequencer takes a step for each completed byte, another if bits are left in the partial
// byte, and a closing step, which also carries the CRC patch transaction on the last
// field when byte 1 bit 0 is clear. The byte sequencer works on one queued item at a
// time and takes the next only once it is through with the last.
// Bytes past HEADER_BYTES come out with byte and index zero and overflow set.
module side_info_packer_crc16 import spcrc_pkg::*; #(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int FIELD_BITS   = FIELD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_field_value,
    input  wire logic [5:0]  i_field_length,
    input  wire logic        i_last_field,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic [6:0]       o_out_index,
    output logic [15:0]      o_crc_word,
    output logic             o_overflow,
    output logic             o_end_of_run
);

    t_item item;
    logic  item_valid;
    logic  pop;

    spcrc_front #(
        .FIELD_BITS (FIELD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_field_value  (i_field_value),
        .i_field_length (i_field_length),
        .i_last_field   (i_last_field),
        .o_item         (item),
        .o_item_valid   (item_valid),
        .i_pop          (pop)
    );

    spcrc_back #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_out_index  (o_out_index),
        .o_crc_word   (o_crc_word),
        .o_overflow   (o_overflow),
        .o_end_of_run (o_end_of_run)
    );

    a_patch_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind == KIND_PATCH) |-> o_end_of_run)
        else $error("patch transaction without end_of_run");

    a_patch_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind == KIND_PATCH) |-> (o_out_index == PATCH_INDEX &&
        o_out_byte == 8'd0))
        else $error("patch transaction with bad index or byte");

    a_data_no_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind == KIND_DATA) |-> (o_crc_word == 16'd0))
        else $error("data transaction with nonzero crc_word");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> item_valid)
        else $error("queue popped while empty");

endmodule
`default_nettype wire

### rtl/spcrc_front.sv
`default_nettype none
module spcrc_front import spcrc_pkg::*; #(
    parameter int FIELD_BITS = FIELD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_field_value,
    input  wire logic [5:0]  i_field_length,
    input  wire logic        i_last_field,
    output t_item            o_item,
    output logic             o_item_valid,
    input  wire logic        i_pop
);

    t_item       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic        push;
    logic [5:0]  len_clamped;

    assign o_in_stall   = (r_count == 2'd2);
    assign push         = i_in_valid && !o_in_stall;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rptr];
    assign len_clamped  = (i_field_length > 6'(FIELD_BITS)) ? 6'(FIELD_BITS) : i_field_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= '{value: i_field_value, length: len_clamped, last: i_last_field};
        end
    end

endmodule
`default_nettype wire

### rtl/spcrc_back.sv
`default_nettype none
module spcrc_back import spcrc_pkg::*; #(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_item       i_item,
    input  wire logic        i_item_valid,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic [6:0]       o_out_index,
    output logic [15:0]      o_crc_word,
    output logic             o_overflow,
    output logic             o_end_of_run
);

    localparam int PW = $clog2(HEADER_BYTES + 1);

    logic          r_busy;
    logic [31:0]   r_val;
    logic [5:0]    r_rem;
    logic          r_last;
    logic [7:0]    r_partial;
    logic [3:0]    r_free;
    logic [PW-1:0] r_pos;
    logic [15:0]   r_crc;
    logic          r_protect;
    logic          r_ovf;

    logic          r_ovalid;
    logic          r_okind;
    logic [7:0]    r_obyte;
    logic [6:0]    r_oindex;
    logic [15:0]   r_ocrc;
    logic          r_oovf;
    logic          r_oeor;

    logic          can_emit;
    logic          step;
    logic          emit;
    logic [3:0]    take;
    logic [5:0]    rem_after;
    logic [31:0]   shifted;
    logic [7:0]    mask;
    logic [7:0]    chunk;
    logic [7:0]    merged;
    logic          complete;
    logic          in_range;
    logic          crc_use;
    logic          n_protect;

    assign can_emit  = !r_ovalid || !i_out_stall;
    assign step      = r_busy && can_emit;
    assign o_pop     = !r_busy && i_item_valid;
    assign emit      = step && ((r_rem != 6'd0) ? complete : (r_last && !r_protect));

    assign take      = (r_rem < {2'b00, r_free}) ? r_rem[3:0] : r_free;
    assign rem_after = r_rem - {2'b00, take};
    assign shifted   = r_val >> rem_after;
    assign mask      = 8'((9'd1 << take) - 9'd1);
    assign chunk     = shifted[7:0] & mask;
    assign merged    = r_partial | (chunk << (r_free - take));
    assign complete  = (take == r_free);
    assign in_range  = (r_pos < PW'(HEADER_BYTES));
    assign crc_use   = in_range && (r_pos >= PW'(CRC_START_POS)) &&
                       (r_pos != PW'(CRC_SKIP_HI)) && (r_pos != PW'(CRC_SKIP_LO));
    assign n_protect = (in_range && (r_pos == PW'(PROTECT_POS))) ? merged[0] : r_protect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_partial <= 8'd0;
            r_free    <= 4'd8;
            r_pos     <= '0;
            r_crc     <= CRC_INIT;
            r_protect <= 1'b0;
            r_ovf     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall && !emit) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_val  <= i_item.value;
                r_rem  <= i_item.length;
                r_last <= i_item.last;
            end else if (step) begin
                if (r_rem != 6'd0) begin
                    r_rem <= rem_after;
                    if (complete) begin
                        r_ovalid  <= 1'b1;
                        r_okind   <= KIND_DATA;
                        r_ocrc    <= 16'd0;
                        r_oeor    <= (rem_after < 6'd8) && !(r_last && !n_protect);
                        r_partial <= 8'd0;
                        r_free    <= 4'd8;
                        if (in_range) begin
                            r_obyte   <= merged;
                            r_oindex  <= 7'(r_pos);
                            r_oovf    <= r_ovf;
                            r_pos     <= r_pos + PW'(1);
                            r_protect <= n_protect;
                            if (crc_use) begin
                                r_crc <= crc16_byte(r_crc, merged);
                            end
                        end else begin
                            r_obyte  <= 8'd0;
                            r_oindex <= 7'd0;
                            r_oovf   <= 1'b1;
                            r_ovf    <= 1'b1;
                        end
                    end else begin
                        r_partial <= merged;
                        r_free    <= r_free - take;
                    end
                end else begin
                    r_busy <= 1'b0;
                    if (r_last) begin
                        if (!r_protect) begin
                            r_ovalid <= 1'b1;
                            r_okind  <= KIND_PATCH;
                            r_obyte  <= 8'd0;
                            r_oindex <= PATCH_INDEX;
                            r_ocrc   <= r_crc;
                            r_oovf   <= r_ovf;
                            r_oeor   <= 1'b1;
                        end
                        r_partial <= 8'd0;
                        r_free    <= 4'd8;
                        r_pos     <= '0;
                        r_crc     <= CRC_INIT;
                        r_protect <= 1'b0;
                        r_ovf     <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_kind   = r_okind;
    assign o_out_byte   = r_obyte;
    assign o_out_index  = r_oindex;
    assign o_crc_word   = r_ocrc;
    assign o_overflow   = r_oovf;
    assign o_end_of_run = r_oeor;

endmodule
`default_nettype wire

### tb/side_info_packer_crc16_test.sv
`timescale 1ns / 1ps

module side_info_packer_crc16_test;
    import spcrc_pkg::*;

    localparam int MAX_BYTES    = HEADER_BYTES_DEF;
    localparam int FIELD_LIMIT  = FIELD_BITS_DEF;
    localparam int RANDOM_ITEMS = 325;
    localparam int QUIET_AFTER  = 280;
    localparam int DIR_ROWS     = 23;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [6:0]  index;
        logic [15:0] crc;
        logic        ovf;
        logic        eor;
    } t_result;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  len;
        logic        last;
        logic        typed;
        logic        has_out;
        t_result     out;
    } t_stim_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [31:0] i_field_value  = '0;
    logic [5:0]  i_field_length = '0;
    logic        i_last_field   = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_out_kind;
    logic [7:0]  o_out_byte;
    logic [6:0]  o_out_index;
    logic [15:0] o_crc_word;
    logic        o_overflow;
    logic        o_end_of_run;

    side_info_packer_crc16 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_field_value (i_field_value),
        .i_field_length(i_field_length),
        .i_last_field  (i_last_field),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_kind    (o_out_kind),
        .o_out_byte    (o_out_byte),
        .o_out_index   (o_out_index),
        .o_crc_word    (o_crc_word),
        .o_overflow    (o_overflow),
        .o_end_of_run  (o_end_of_run)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // packer state as predicted
    logic [7:0]  acc_byte;
    int          free_cnt;
    int          hdr_pos;
    logic [15:0] crc_acc;
    logic        prot_off;
    logic        ovf_flag;

    t_result pending_results[$];
    int      mismatch_count = 0;
    int      results_seen   = 0;
    int      random_sent    = 0;
    bit      idle_on        = 1'b0;
    int      stall_left     = 0;
    t_result got;
    t_result want;

    t_stim_row dir_tbl [0:DIR_ROWS-1] = '{
        '{32'h0000_0000, 6'd0,  1'b1, 1'b1, 1'b1,
          '{KIND_PATCH, 8'h00, PATCH_INDEX, 16'hFFFF, 1'b0, 1'b1}},
        '{32'h0000_0000, 6'd0,  1'b0, 1'b1, 1'b0, '0},
        '{32'hFFFF_FFFF, 6'd8,  1'b0, 1'b1, 1'b1,
          '{KIND_DATA, 8'hFF, 7'd0, 16'h0000, 1'b0, 1'b1}},
        '{32'h0000_0001, 6'd8,  1'b0, 1'b1, 1'b1,
          '{KIND_DATA, 8'h01, 7'd1, 16'h0000, 1'b0, 1'b1}},
        '{32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 6'd0,  1'b1, 1'b1, 1'b0, '0},
        '{32'hA5A5_A5A5, 6'd63, 1'b0, 1'b0, 1'b0, '0},
        '{32'h1234_5678, 6'd32, 1'b0, 1'b0, 1'b0, '0},
        '{32'h0000_0003, 6'd3,  1'b0, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 6'd1,  1'b1, 1'b0, 1'b0, '0},
        '{32'h8000_0001, 6'd1,  1'b0, 1'b0, 1'b0, '0},
        '{32'h0000_007F, 6'd7,  1'b0, 1'b0, 1'b0, '0},
        '{32'h0000_00FE, 6'd8,  1'b0, 1'b0, 1'b0, '0},
        '{32'hDEAD_BEEF, 6'd32, 1'b0, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 6'd32, 1'b0, 1'b0, 1'b0, '0},
        '{32'h0000_0005, 6'd5,  1'b1, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 6'd0,  1'b0, 1'b1, 1'b0, '0},
        '{32'h0000_00FF, 6'd16, 1'b0, 1'b0, 1'b0, '0},
        '{32'hABCD_EF01, 6'd24, 1'b1, 1'b0, 1'b0, '0},
        '{32'h0000_001F, 6'd33, 1'b0, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 6'd32, 1'b1, 1'b0, 1'b0, '0},
        '{32'h5555_5555, 6'd31, 1'b0, 1'b0, 1'b0, '0},
        '{32'hAAAA_AAAA, 6'd32, 1'b1, 1'b0, 1'b0, '0}
    };

    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ d[k];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] rand_len();
        if ($urandom_range(0, 9) == 0) begin
            return 6'($urandom_range(FIELD_LIMIT + 1, 63));
        end
        return 6'($urandom_range(0, FIELD_LIMIT));
    endfunction

    task automatic clear_header();
        acc_byte = '0;
        free_cnt = 8;
        hdr_pos  = 0;
        crc_acc  = CRC_INIT;
        prot_off = 1'b0;
        ovf_flag = 1'b0;
    endtask

    task automatic pack_field(input logic [31:0] v, input logic [5:0] len_in,
                              input logic l, output int n);
        t_result res [0:4];
        int      len;
        n   = 0;
        len = (len_in > FIELD_LIMIT) ? FIELD_LIMIT : int'(len_in);
        for (int i = len - 1; i >= 0; i--) begin
            free_cnt--;
            acc_byte[free_cnt] = v[i];
            if (free_cnt == 0) begin
                res[n] = '0;
                if (hdr_pos < MAX_BYTES) begin
                    if (hdr_pos == PROTECT_POS) begin
                        prot_off = acc_byte[0];
                    end
                    if (hdr_pos >= CRC_START_POS && hdr_pos != CRC_SKIP_HI &&
                        hdr_pos != CRC_SKIP_LO) begin
                        crc_acc = crc_next(crc_acc, acc_byte);
                    end
                    res[n].kind  = KIND_DATA;
                    res[n].data  = acc_byte;
                    res[n].index = 7'(hdr_pos);
                    hdr_pos++;
                end else begin
                    ovf_flag = 1'b1;
                end
                res[n].ovf = ovf_flag;
                n++;
                acc_byte = '0;
                free_cnt = 8;
            end
        end
        if (l) begin
            if (!prot_off) begin
                res[n]       = '0;
                res[n].kind  = KIND_PATCH;
                res[n].index = PATCH_INDEX;
                res[n].crc   = crc_acc;
                res[n].ovf   = ovf_flag;
                n++;
            end
            clear_header();
        end
        if (n > 0) begin
            res[n-1].eor = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            pending_results.push_back(res[k]);
        end
    endtask

    task automatic send_field(input logic [31:0] v, input logic [5:0] len, input logic l,
                              output int n);
        int gap;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_field_value  <= v;
        i_field_length <= len;
        i_last_field   <= l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pack_field(v, len, l, n);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] g,
                                   input logic [31:0] w);
        $display("%0t: mismatch on %s, result %0d: got %0h, expected %0h",
                 $realtime, what, results_seen, g, w);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) begin
                i_out_stall <= 1'b0;
            end
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9);
            i_out_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_out_kind, o_out_byte, o_out_index, o_crc_word, o_overflow, o_end_of_run};
            if (pending_results.size() == 0) begin
                report_mismatch("transaction with nothing pending", 32'(got), 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("out_kind", 32'(got.kind), 32'(want.kind));
                if (got.data !== want.data)
                    report_mismatch("out_byte", 32'(got.data), 32'(want.data));
                if (got.index !== want.index)
                    report_mismatch("out_index", 32'(got.index), 32'(want.index));
                if (got.crc !== want.crc)
                    report_mismatch("crc_word", 32'(got.crc), 32'(want.crc));
                if (got.ovf !== want.ovf)
                    report_mismatch("overflow", 32'(got.ovf), 32'(want.ovf));
                if (got.eor !== want.eor)
                    report_mismatch("end_of_run", 32'(got.eor), 32'(want.eor));
            end
            results_seen++;
        end
    end

    initial begin
        int n;
        int hdr_count;
        int n_fields;
        int pick;
        clear_header();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b1;
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_field(dir_tbl[r].value, dir_tbl[r].len, dir_tbl[r].last, n);
            if (dir_tbl[r].typed) begin
                repeat (n) void'(pending_results.pop_back());
                if (dir_tbl[r].has_out) begin
                    pending_results.push_back(dir_tbl[r].out);
                end
            end
        end

        hdr_count = 0;
        while (random_sent < RANDOM_ITEMS) begin
            hdr_count++;
            idle_on = (random_sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
            // hold until the block has drained
            if (hdr_count == 8) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 24);
            if (hdr_count == 3 || hdr_count == 15 || pick == 0) begin
                n_fields = $urandom_range(33, 40);
                for (int f = 0; f < n_fields; f++) begin
                    send_field($urandom, 6'd32, f == n_fields - 1, n);
                end
            end else if (pick <= 3) begin
                n_fields = $urandom_range(1, 6);
                for (int f = 0; f < n_fields; f++) begin
                    send_field($urandom, rand_len(), $urandom_range(0, 3) == 0, n);
                end
            end else begin
                n_fields = $urandom_range(1, 12);
                for (int f = 0; f < n_fields; f++) begin
                    send_field($urandom, rand_len(), f == n_fields - 1, n);
                end
            end
            random_sent += n_fields;
        end
        idle_on = 1'b0;
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
